/* sv/csvs_pkg.sv */
package csvs_pkg;

	localparam int BYTE_W   = 8;
	localparam int FIELD_W  = 8;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int MAX_FIELD_DEF = 128;

	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA           = 2'd0,
		KIND_FIELD_END      = 2'd1,
		KIND_DONE_FOUND     = 2'd2,
		KIND_DONE_NOT_FOUND = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_FIELD     = 2'd0,
		CFG_STOP_ON_LINE_END = 2'd1,
		CFG_UNUSED_2         = 2'd2,
		CFG_UNUSED_3         = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   out_byte;
		logic [FIELD_W-1:0]  field_number;
		logic                last;
	} result_t;

	// up to two results produced by one input byte, in order
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	typedef struct packed {
		logic [FIELD_W-1:0] target_field;
		logic               stop_on_line_end;
	} cfg_t;

endpackage

/* sv/csvs_intf.sv */
interface csvs_in_if;
	logic                          valid;
	logic                          ready;
	logic [csvs_pkg::BYTE_W-1:0]   in_byte;
	logic                          record_end;

	modport source (output valid, output in_byte, output record_end, input ready);
	modport sink   (input valid, input in_byte, input record_end, output ready);
endinterface

interface csvs_out_if;
	logic                          valid;
	logic                          ready;
	logic [csvs_pkg::KIND_W-1:0]   kind;
	logic [csvs_pkg::BYTE_W-1:0]   out_byte;
	logic [csvs_pkg::FIELD_W-1:0]  field_number;
	logic                          last;

	modport source (output valid, output kind, output out_byte, output field_number,
		output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input field_number,
		input last, output ready);
endinterface

interface csvs_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [csvs_pkg::CFG_IDX_W-1:0]  index;
	logic [csvs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/csvs_parser.sv */
module csvs_parser #(
	parameter int MAX_FIELD = csvs_pkg::MAX_FIELD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [csvs_pkg::BYTE_W-1:0] in_byte,
	input  logic                        record_end,
	input  csvs_pkg::cfg_t              cfg,
	output csvs_pkg::push_t             push
);
	localparam int CNT_W = $clog2(MAX_FIELD);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FIELD - 1);

	logic                         in_quote_q, in_quote_d;
	logic [csvs_pkg::FIELD_W-1:0] field_index_q, field_index_d;
	logic [CNT_W-1:0]             byte_count_q, byte_count_d;
	logic                         halted_q, halted_d;
	logic                         found_q, found_d;

	logic                         split, in_target, line_end;
	logic                         e_valid;
	csvs_pkg::result_t            e_res, d_res;

	always_comb begin
		split     = (cfg.target_field == '0);
		in_target = split || (({1'b0, field_index_q} + 9'd1) == {1'b0, cfg.target_field});
		line_end  = !in_quote_q && cfg.stop_on_line_end &&
			(in_byte == csvs_pkg::CH_CR || in_byte == csvs_pkg::CH_LF);

		in_quote_d    = in_quote_q;
		field_index_d = field_index_q;
		byte_count_d  = byte_count_q;
		halted_d      = halted_q;
		found_d       = found_q;

		e_valid = 1'b0;
		e_res.kind         = csvs_pkg::KIND_DATA;
		e_res.out_byte     = in_byte;
		e_res.field_number = field_index_q;
		e_res.last         = !record_end;

		if (!halted_q) begin
			if (line_end) begin
				halted_d = 1'b1;
			end else begin
				if (in_target)
					found_d = 1'b1;
				if (in_byte == csvs_pkg::CH_QUOTE) begin
					in_quote_d = !in_quote_q;
				end else if (in_byte == csvs_pkg::CH_COMMA && !in_quote_q) begin
					if (split) begin
						e_valid        = 1'b1;
						e_res.kind     = csvs_pkg::KIND_FIELD_END;
						e_res.out_byte = '0;
					end
					if (field_index_q != csvs_pkg::FIELD_MAX)
						field_index_d = field_index_q + 1'b1;
					byte_count_d = '0;
				end else if (in_target) begin
					if (split) begin
						e_valid = 1'b1;
					end else if (byte_count_q < CNT_LIMIT) begin
						e_valid      = 1'b1;
						byte_count_d = byte_count_q + 1'b1;
					end
				end
			end
		end

		// record done reports the state as left by this byte
		d_res.kind         = found_d ? csvs_pkg::KIND_DONE_FOUND
			: csvs_pkg::KIND_DONE_NOT_FOUND;
		d_res.out_byte     = '0;
		d_res.field_number = field_index_d;
		d_res.last         = 1'b1;

		push.v0 = accept && (e_valid || record_end);
		push.v1 = accept && e_valid && record_end;
		push.r0 = e_valid ? e_res : d_res;
		push.r1 = d_res;

		if (record_end) begin
			in_quote_d    = 1'b0;
			field_index_d = '0;
			byte_count_d  = '0;
			halted_d      = 1'b0;
			found_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q    <= 1'b0;
			field_index_q <= '0;
			byte_count_q  <= '0;
			halted_q      <= 1'b0;
			found_q       <= 1'b0;
		end else if (accept) begin
			in_quote_q    <= in_quote_d;
			field_index_q <= field_index_d;
			byte_count_q  <= byte_count_d;
			halted_q      <= halted_d;
			found_q       <= found_d;
		end
	end

endmodule

/* sv/csvs_result_fifo.sv */
module csvs_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  csvs_pkg::push_t   push,
	output logic              room,
	output logic              valid,
	input  logic              ready,
	output csvs_pkg::result_t head
);
	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	csvs_pkg::result_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               pop;
	logic [1:0]         n_push;

	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign pop    = valid && ready;
	// two free slots needed so any input byte can be taken
	assign room   = (count_q <= (PTR_W+1)'(DEPTH - 2));
	assign n_push = {1'b0, push.v0} + {1'b0, push.v1};

	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.v1)
			mem_q[wr_ptr_q + 1'b1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
		end
	end

endmodule

/* sv/csv_field_splitter.sv */
// CSV field splitter.
// in_ch takes one record byte per request; record_end marks the record's last
// byte. out_ch gives result records: data bytes, field ends (split-all mode)
// and one record-done result per record, with last set on the final result
// of each input byte. cfg_ch writes target_field (index 0) and
// stop_on_line_end (index 1); it is always ready, and writes belong between
// records while the block is idle.
// Results are queued as their input byte is accepted; out_ch shows the
// queue head. Throughput: one input byte per cycle while the four-entry result
// queue has two free slots; output drains one result per cycle, so bytes that
// produce two results limit the sustained rate to one result per cycle.
// Receiver stall: the queue fills and in_ch.ready drops until two slots free;
// nothing is lost or repeated.
// Reset: parse state clears, queue empties, target_field = 0 (split all),
// stop_on_line_end = 1.
module csv_field_splitter #(
	parameter int MAX_FIELD = csvs_pkg::MAX_FIELD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	csvs_in_if.sink     in_ch,
	csvs_out_if.source  out_ch,
	csvs_cfg_if.sink    cfg_ch
);
	csvs_pkg::cfg_t    cfg_q;
	csvs_pkg::push_t   push;
	csvs_pkg::result_t head;
	logic              room;
	logic              accept;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = room;
	assign accept       = in_ch.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_field     <= '0;
			cfg_q.stop_on_line_end <= 1'b1;
		end else if (cfg_ch.valid) begin
			unique case (csvs_pkg::cfg_idx_t'(cfg_ch.index))
				csvs_pkg::CFG_TARGET_FIELD:
					cfg_q.target_field <= cfg_ch.data[csvs_pkg::FIELD_W-1:0];
				csvs_pkg::CFG_STOP_ON_LINE_END:
					cfg_q.stop_on_line_end <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	csvs_parser #(
		.MAX_FIELD(MAX_FIELD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_ch.in_byte),
		.record_end (in_ch.record_end),
		.cfg        (cfg_q),
		.push       (push)
	);

	csvs_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (out_ch.valid),
		.ready  (out_ch.ready),
		.head   (head)
	);

	assign out_ch.kind         = head.kind;
	assign out_ch.out_byte     = head.out_byte;
	assign out_ch.field_number = head.field_number;
	assign out_ch.last         = head.last;

endmodule

/* test/csv_field_splitter_tb.sv */
`timescale 1ns / 1ps

module csv_field_splitter_tb;

	localparam int MAX_FIELD     = csvs_pkg::MAX_FIELD_DEF;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 150;
	localparam int CYCLE_LIMIT   = 400000;

	logic clk;
	logic arst_n;

	csvs_in_if  in_ch ();
	csvs_out_if out_ch ();
	csvs_cfg_if cfg_ch ();

	csv_field_splitter #(.MAX_FIELD(MAX_FIELD)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// parser mirror: registers and per-record state
	logic [csvs_pkg::FIELD_W-1:0] sel_field    = '0;
	logic                         halt_on_eol  = 1'b1;
	logic                         quoted       = 1'b0;
	logic [csvs_pkg::FIELD_W-1:0] cur_field    = '0;
	int                           field_bytes  = 0;
	logic                         line_stopped = 1'b0;
	logic                         hit          = 1'b0;

	csvs_pkg::result_t pending_results[$];

	int  mismatches   = 0;
	int  results_seen = 0;
	int  bytes_in     = 0;
	int  records_in   = 0;
	int  cfg_writes   = 0;
	int  cycle_cnt    = 0;
	bit  src_idle     = 1'b0;
	bit  sink_idle    = 1'b0;
	bit  hold_on      = 1'b0;
	int  sink_gap     = 0;
	event hold_go;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic csvs_pkg::result_t make_result(input csvs_pkg::kind_t k,
			input logic [csvs_pkg::BYTE_W-1:0] b, input logic [csvs_pkg::FIELD_W-1:0] f);
		csvs_pkg::result_t r;
		r.kind         = k;
		r.out_byte     = b;
		r.field_number = f;
		r.last         = 1'b0;
		return r;
	endfunction

	// works out the results one record byte causes and queues them
	function automatic void parse_byte(input logic [csvs_pkg::BYTE_W-1:0] b,
			input logic rec_end);
		csvs_pkg::result_t outs [2];
		int                n;
		bit                split_all;
		bit                in_sel;
		n = 0;
		if (!line_stopped) begin
			split_all = (sel_field == '0);
			in_sel = split_all || (int'(cur_field) + 1 == int'(sel_field));
			if (!quoted && (b == csvs_pkg::CH_CR || b == csvs_pkg::CH_LF) && halt_on_eol) begin
				line_stopped = 1'b1;
			end else begin
				if (in_sel)
					hit = 1'b1;
				if (b == csvs_pkg::CH_QUOTE) begin
					quoted = !quoted;
				end else if (b == csvs_pkg::CH_COMMA && !quoted) begin
					if (split_all) begin
						outs[n] = make_result(csvs_pkg::KIND_FIELD_END, 8'h00, cur_field);
						n++;
					end
					if (cur_field != csvs_pkg::FIELD_MAX)
						cur_field++;
					field_bytes = 0;
				end else if (in_sel && (split_all || field_bytes < MAX_FIELD - 1)) begin
					outs[n] = make_result(csvs_pkg::KIND_DATA, b, cur_field);
					n++;
					if (!split_all)
						field_bytes++;
				end
			end
		end
		if (rec_end) begin
			outs[n] = make_result(hit ? csvs_pkg::KIND_DONE_FOUND
				: csvs_pkg::KIND_DONE_NOT_FOUND, 8'h00, cur_field);
			n++;
			quoted       = 1'b0;
			cur_field    = '0;
			field_bytes  = 0;
			line_stopped = 1'b0;
			hit          = 1'b0;
		end
		if (n > 0)
			outs[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.insert(pending_results.size(), outs[i]);
	endfunction

	// accepted requests on the input and register channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				parse_byte(in_ch.in_byte, in_ch.record_end);
				bytes_in++;
				if (in_ch.record_end)
					records_in++;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				cfg_writes++;
				case (csvs_pkg::cfg_idx_t'(cfg_ch.index))
					csvs_pkg::CFG_TARGET_FIELD: sel_field = cfg_ch.data;
					csvs_pkg::CFG_STOP_ON_LINE_END: halt_on_eol = cfg_ch.data[0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		csvs_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: kind=%0d byte=%02h field=%0d last=%0b",
						out_ch.kind, out_ch.out_byte, out_ch.field_number, out_ch.last);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.kind !== want.kind || out_ch.out_byte !== want.out_byte ||
						out_ch.field_number !== want.field_number ||
						out_ch.last !== want.last) begin
					if (mismatches < 10) begin
						$display("mismatch: exp kind=%0d byte=%02h field=%0d last=%0b",
							want.kind, want.out_byte, want.field_number, want.last);
						$display("          got kind=%0d byte=%02h field=%0d last=%0b",
							out_ch.kind, out_ch.out_byte, out_ch.field_number, out_ch.last);
					end
					mismatches++;
				end
			end
		end
	end

	// output side: random stall bursts, or a long hold-off
	always @(posedge clk) begin
		if (hold_on) begin
			out_ch.ready <= 1'b0;
		end else if (sink_gap != 0) begin
			out_ch.ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (sink_idle && $urandom_range(0, 7) == 0) begin
			out_ch.ready <= 1'b0;
			sink_gap <= $urandom_range(0, 5);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	task automatic send_byte(input logic [csvs_pkg::BYTE_W-1:0] b, input logic rec_end);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.in_byte    <= b;
		in_ch.record_end <= rec_end;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input csvs_pkg::cfg_idx_t idx,
			input logic [csvs_pkg::CFG_DATA_W-1:0] v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [csvs_pkg::BYTE_W-1:0] random_text_byte();
		case ($urandom_range(0, 19))
			0, 1, 2: return csvs_pkg::CH_COMMA;
			3, 4: return csvs_pkg::CH_QUOTE;
			5: return csvs_pkg::CH_CR;
			6: return csvs_pkg::CH_LF;
			7, 8, 9, 10, 11, 12, 13: return 8'($urandom_range(8'h61, 8'h7a));
			default: return 8'($urandom);
		endcase
	endfunction

	// reset values: split all, stop at line end
	task automatic test_split_directed();
		send_text("a,b");
		send_text(",");
		send_text("\"x,\012y\"");
		send_text("\"\"");
		send_text("\012");
		send_text("\015a,b");
		send_text("\"a,b");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_select_directed();
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd2);
		write_reg(csvs_pkg::CFG_STOP_ON_LINE_END, 8'd0);
		send_text("aa,bb,cc");
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd3);
		// trailing comma opens the target field but it has no byte of its own
		send_text("a,b,");
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd1);
		send_text("a\015b");
		// unused register slots must leave the parser alone
		write_reg(csvs_pkg::CFG_UNUSED_2, 8'($urandom));
		write_reg(csvs_pkg::CFG_UNUSED_3, 8'hFF);
		send_text("c,d");
	endtask

	task automatic test_truncation();
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd1);
		write_reg(csvs_pkg::CFG_STOP_ON_LINE_END, 8'd1);
		for (int i = 0; i < MAX_FIELD + 12; i++)
			send_byte(8'($urandom_range(8'h30, 8'h7e)), 1'b0);
		send_text(",y");
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd2);
		// long quoted second field with commas inside it
		send_byte(8'h70, 1'b0);
		send_byte(csvs_pkg::CH_COMMA, 1'b0);
		send_byte(csvs_pkg::CH_QUOTE, 1'b0);
		for (int i = 0; i < MAX_FIELD + 2; i++)
			send_byte(($urandom_range(0, 7) == 0) ? csvs_pkg::CH_COMMA
				: 8'($urandom_range(8'h41, 8'h5a)), 1'b0);
		send_text("\"");
	endtask

	task automatic test_field_saturation();
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd0);
		for (int i = 0; i < 260; i++)
			send_byte(csvs_pkg::CH_COMMA, 1'b0);
		send_text("z,w");
		write_reg(csvs_pkg::CFG_TARGET_FIELD, csvs_pkg::FIELD_MAX);
		for (int i = 0; i < int'(csvs_pkg::FIELD_MAX) - 1; i++)
			send_byte(csvs_pkg::CH_COMMA, 1'b0);
		send_text("ab,cd,,,e");
	endtask

	task automatic test_output_hold();
		write_reg(csvs_pkg::CFG_TARGET_FIELD, 8'd0);
		src_idle = 1'b0;
		-> hold_go;
		// comma on a record end gives two results, which fills the queue fast
		for (int i = 0; i < 48; i++)
			send_byte(($urandom_range(0, 1) != 0) ? csvs_pkg::CH_COMMA
				: 8'($urandom_range(8'h61, 8'h7a)), (i % 6) == 5);
		src_idle = 1'b1;
	endtask

	task automatic test_random_traffic(input logic [csvs_pkg::FIELD_W-1:0] tgt,
			input logic eol, input int n_bytes);
		int sent;
		int len;
		write_reg(csvs_pkg::CFG_TARGET_FIELD, tgt);
		write_reg(csvs_pkg::CFG_STOP_ON_LINE_END, {7'd0, eol});
		sent = 0;
		while (sent < n_bytes) begin
			len = $urandom_range(1, 24);
			for (int i = 0; i < len; i++)
				send_byte(random_text_byte(), i == len - 1);
			sent += len;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.in_byte    = '0;
		in_ch.record_end = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = csvs_pkg::CFG_TARGET_FIELD;
		cfg_ch.data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 1'b1;
		sink_idle <= 1'b1;
		test_split_directed();
		test_select_directed();
		test_truncation();
		test_field_saturation();
		test_output_hold();

		test_random_traffic(8'd0, 1'b1, 30);
		test_random_traffic(8'd0, 1'b0, 30);
		test_random_traffic(8'($urandom_range(1, 4)), 1'b1, 30);
		test_random_traffic(8'($urandom_range(1, 4)), 1'b0, 30);
		test_random_traffic(csvs_pkg::FIELD_MAX, 1'b0, 15);
		// closing stretch runs flat out on both sides
		src_idle = 1'b0;
		sink_idle <= 1'b0;
		test_random_traffic(8'd0, 1'b1, 50);

		wait_idle();
		$display("ran %0d bytes in %0d records, checked %0d results, %0d register writes",
			bytes_in, records_in, results_seen, cfg_writes);
		$display("split-all/select modes, quotes, line-end stops, truncation, saturation, hold-off");
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
